// ===== design/magnetometer_calibrate_heading_assert.svh =====
// Assertion macros shared by the magnetometer calibration and heading design.
`ifndef MAGNETOMETER_CALIBRATE_HEADING_ASSERT_SVH
`define MAGNETOMETER_CALIBRATE_HEADING_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define MCH_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define MCH_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/mch_pkg.sv =====
// Package with the types, constants and arctangent table of the heading design.
package mch_pkg;

  localparam int RawW      = 16;
  localparam int ScaledW   = 17;
  localparam int OffW      = 20;
  localparam int CoefW     = 16;
  localparam int OfsAxisW  = 21;
  localparam int CalW      = 39;
  localparam int CordicW   = 45;
  localparam int AngleW    = 34;
  localparam int AtanLen   = 24;
  localparam int NormTopBit = 40;
  localparam int DefaultAngleIterations = 16;

  localparam logic [59:0] HardIronReset   = 60'd0;
  localparam logic [47:0] SoftDiagReset   = 48'h400040004000;
  localparam logic [47:0] SoftCrossReset  = 48'd0;

  localparam logic [AngleW-1:0] TurnQuarter = AngleW'(64'd1073741824);
  localparam logic [AngleW-1:0] TurnHalf    = AngleW'(64'd2147483648);
  localparam logic [11:0] FullCircle = 12'd3600;

  // Configuration register indices (paddr[4:3]), in register index order.
  typedef enum logic [1:0] {
    RegHardIron  = 2'd0,
    RegSoftDiag  = 2'd1,
    RegSoftCross = 2'd2
  } reg_index_t;

  // Arctangent of 2^-i in units of 2^-32 turn.
  function automatic logic [AngleW-1:0] atan_turns(input int i);
    logic [AngleW-1:0] r;
    case (i)
      0: r = AngleW'(64'd536870912);   1: r = AngleW'(64'd316933406);
      2: r = AngleW'(64'd167458907);   3: r = AngleW'(64'd85004756);
      4: r = AngleW'(64'd42667331);    5: r = AngleW'(64'd21354465);
      6: r = AngleW'(64'd10679838);    7: r = AngleW'(64'd5340245);
      8: r = AngleW'(64'd2670163);     9: r = AngleW'(64'd1335087);
      10: r = AngleW'(64'd667544);     11: r = AngleW'(64'd333772);
      12: r = AngleW'(64'd166886);     13: r = AngleW'(64'd83443);
      14: r = AngleW'(64'd41722);      15: r = AngleW'(64'd20861);
      16: r = AngleW'(64'd10430);      17: r = AngleW'(64'd5215);
      18: r = AngleW'(64'd2608);       19: r = AngleW'(64'd1304);
      20: r = AngleW'(64'd652);        21: r = AngleW'(64'd326);
      22: r = AngleW'(64'd163);        23: r = AngleW'(64'd81);
      default: r = '0;
    endcase
    return r;
  endfunction

  // Side data that rides along the heading pipeline.
  typedef struct packed {
    logic signed [ScaledW-1:0] scaled_x;
    logic signed [ScaledW-1:0] scaled_y;
    logic signed [ScaledW-1:0] scaled_z;
    logic signed [RawW-1:0]    cal_x;
    logic signed [RawW-1:0]    cal_y;
    logic signed [RawW-1:0]    cal_z;
  } side_t;

  // Sign and zero flags of the calibrated X and Y.
  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic zero;
  } quad_t;

endpackage

// ===== design/mch_cordic.sv =====
// Pipelined CORDIC vectoring that gives the heading in tenths of a degree.
module mch_cordic #(
  parameter int AngleIterations = mch_pkg::DefaultAngleIterations
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic [mch_pkg::CalW-1:0] in_ax,
  input  logic [mch_pkg::CalW-1:0] in_ay,
  input  mch_pkg::quad_t in_quad,
  input  mch_pkg::side_t in_side,
  output logic out_valid,
  output logic [11:0] out_heading,
  output mch_pkg::side_t out_side
);
  import mch_pkg::*;

  localparam int Steps = (AngleIterations < AtanLen) ? AngleIterations : AtanLen;
  localparam int NormW = $clog2(NormTopBit + 1);

  // Normalize stage: shift left until the larger operand reaches bit 40.
  logic              n_valid;
  logic [CordicW-1:0] n_x, n_y;
  quad_t             n_quad;
  side_t             n_side;
  logic [CalW-1:0]   big;
  logic [NormW-1:0]  lz;

  always_comb begin
    big = (in_ax > in_ay) ? in_ax : in_ay;
    lz = '0;
    for (int b = 0; b < CalW; b++) begin
      if (big[b]) lz = NormW'(NormTopBit - b);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) n_valid <= 1'b0;
    else if (en) n_valid <= in_valid;
    if (en) begin
      n_x    <= CordicW'(in_ax) << lz;
      n_y    <= CordicW'(in_ay) << lz;
      n_quad <= in_quad;
      n_side <= in_side;
    end
  end

  // One register stage per rotation.
  logic                     s_valid [Steps+1];
  logic signed [CordicW-1:0] s_x [Steps+1];
  logic signed [CordicW-1:0] s_y [Steps+1];
  logic signed [AngleW:0]    s_z [Steps+1];
  quad_t                    s_quad [Steps+1];
  side_t                    s_side [Steps+1];

  assign s_valid[0] = n_valid;
  assign s_x[0] = n_x;
  assign s_y[0] = n_y;
  assign s_z[0] = '0;
  assign s_quad[0] = n_quad;
  assign s_side[0] = n_side;

  for (genvar i = 0; i < Steps; i++) begin : g_rot
    always_ff @(posedge clk) begin
      if (rst) s_valid[i+1] <= 1'b0;
      else if (en) s_valid[i+1] <= s_valid[i];
      if (en) begin
        if (!s_y[i][CordicW-1]) begin
          s_x[i+1] <= s_x[i] + (s_y[i] >>> i);
          s_y[i+1] <= s_y[i] - (s_x[i] >>> i);
          s_z[i+1] <= s_z[i] + $signed({1'b0, atan_turns(i)});
        end else begin
          s_x[i+1] <= s_x[i] - (s_y[i] >>> i);
          s_y[i+1] <= s_y[i] + (s_x[i] >>> i);
          s_z[i+1] <= s_z[i] - $signed({1'b0, atan_turns(i)});
        end
        s_quad[i+1] <= s_quad[i];
        s_side[i+1] <= s_side[i];
      end
    end
  end

  // Quadrant stage: clamp, restore quadrant, negate.
  logic               q_valid;
  logic signed [AngleW:0] q_h;
  quad_t              q_quad;
  side_t              q_side;
  logic signed [AngleW:0] zc, th;

  always_comb begin
    zc = s_z[Steps];
    if (zc < 0) zc = '0;
    if (zc > $signed({1'b0, TurnQuarter})) zc = $signed({1'b0, TurnQuarter});
    if (!s_quad[Steps].neg_x) th = s_quad[Steps].neg_y ? -zc : zc;
    else begin
      th = $signed({1'b0, TurnHalf}) - zc;
      if (s_quad[Steps].neg_y) th = -th;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) q_valid <= 1'b0;
    else if (en) q_valid <= s_valid[Steps];
    if (en) begin
      q_h    <= -th;
      q_quad <= s_quad[Steps];
      q_side <= s_side[Steps];
    end
  end

  // Scale stage: h*3600/2^32 toward zero, wrap negatives, zero if X and Y are both zero.
  logic signed [AngleW+12:0] prod;
  logic [AngleW+12:0]        mag;
  logic signed [13:0]        t;
  always_comb begin
    prod = q_h * $signed({1'b0, FullCircle});
    mag  = prod[AngleW+12] ? -prod : prod;
    t    = 14'(mag >> 32);
    if (prod[AngleW+12]) t = -t;
    if (t < 0) t = t + 14'sd3600;
    if (q_quad.zero) t = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= q_valid;
    if (en) begin
      out_heading <= t[11:0];
      out_side    <= q_side;
    end
  end

endmodule

// ===== design/magnetometer_calibrate_heading.sv =====
// Item path: stages 1-3, CORDIC normalize, rotation, quadrant and scale stages.
// Throughput: one item per cycle; each CORDIC rotation has its own register stage.
// A stall on the output freezes the whole pipeline; nothing is lost or repeated.
// Reset (rst, synchronous) clears all valid bits and loads the register defaults.
// Configuration is held in three registers written through the APB port.
// Top level: scaling, hard/soft-iron calibration and heading pipeline.
module magnetometer_calibrate_heading #(
  parameter int ANGLE_ITERATIONS = mch_pkg::DefaultAngleIterations
) (
  input  logic clk,
  input  logic rst,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [4:0] paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic pready,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [47:0] s_tdata,   // raw_x, raw_y, raw_z
  output logic m_tvalid,
  input  logic m_tready,
  output logic [111:0] m_tdata   // scaled_x/y/z, cal_x/y/z, heading_tenths, zero pad
);
  import mch_pkg::*;

  logic [59:0] hard_iron;
  logic [47:0] soft_diag, soft_cross;
  logic en;

  // Register file.
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      hard_iron  <= HardIronReset;
      soft_diag  <= SoftDiagReset;
      soft_cross <= SoftCrossReset;
    end else if (psel && penable && pwrite && paddr[2:0] == 3'd0) begin
      unique case (paddr[4:3])
        RegHardIron:  hard_iron  <= pwdata[59:0];
        RegSoftDiag:  soft_diag  <= pwdata[47:0];
        RegSoftCross: soft_cross <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[4:3])
      RegHardIron:  prdata = {4'd0, hard_iron};
      RegSoftDiag:  prdata = {16'd0, soft_diag};
      RegSoftCross: prdata = {16'd0, soft_cross};
      default: prdata = '0;
    endcase
  end

  // Pipeline advances when the output register can move.
  assign en = !m_tvalid || m_tready;
  assign s_tready = en;

  // Stage 1: scale and subtract offsets.
  logic v1;
  logic signed [OfsAxisW-1:0] o1 [3];
  logic signed [ScaledW-1:0] sc1 [3];
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= s_tvalid;
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        o1[k] <= OfsAxisW'($signed(s_tdata[16*k +: 16]) * 12)
                 - OfsAxisW'($signed(hard_iron[20*k +: 20]));
        sc1[k] <= ScaledW'(($signed(s_tdata[16*k +: 16]) * 3) / 2);
      end
    end
  end

  // Stage 2: nine products.
  logic v2;
  logic signed [CalW-1:0] p2 [3][3];
  logic signed [ScaledW-1:0] sc2 [3];
  logic signed [CoefW-1:0] cf [3][3];
  always_comb begin
    cf[0][0] = soft_diag[15:0];   cf[1][1] = soft_diag[31:16]; cf[2][2] = soft_diag[47:32];
    cf[0][1] = soft_cross[15:0];  cf[1][0] = soft_cross[15:0];
    cf[0][2] = soft_cross[31:16]; cf[2][0] = soft_cross[31:16];
    cf[1][2] = soft_cross[47:32]; cf[2][1] = soft_cross[47:32];
  end
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) p2[r][k] <= CalW'(cf[r][k] * o1[k]);
      end
      sc2 <= sc1;
    end
  end

  // Stage 3: sums, truncation, saturation, magnitudes.
  logic signed [CalW-1:0] c [3];
  logic signed [CalW-1:0] q [3];
  logic signed [RawW-1:0] cal [3];
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      c[r] = p2[r][0] + p2[r][1] + p2[r][2];
      q[r] = c[r][CalW-1] ? -((-c[r]) >>> 17) : (c[r] >>> 17);
      if (q[r] > 32767) cal[r] = 16'sh7fff;
      else if (q[r] < -32768) cal[r] = -16'sh8000;
      else cal[r] = RawW'(q[r]);
    end
  end

  logic v3;
  logic [CalW-1:0] ax3, ay3;
  quad_t quad3;
  side_t side3;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
    if (en) begin
      ax3 <= c[0][CalW-1] ? CalW'(-c[0]) : CalW'(c[0]);
      ay3 <= c[1][CalW-1] ? CalW'(-c[1]) : CalW'(c[1]);
      quad3 <= '{neg_x: c[0][CalW-1], neg_y: c[1][CalW-1], zero: c[0] == 0 && c[1] == 0};
      side3 <= '{scaled_x: sc2[0], scaled_y: sc2[1], scaled_z: sc2[2],
                 cal_x: cal[0], cal_y: cal[1], cal_z: cal[2]};
    end
  end

  logic [11:0] heading;
  side_t side_o;
  mch_cordic #(.AngleIterations(ANGLE_ITERATIONS)) u_cordic (
    .clk, .rst, .en,
    .in_valid(v3), .in_ax(ax3), .in_ay(ay3), .in_quad(quad3), .in_side(side3),
    .out_valid(m_tvalid), .out_heading(heading), .out_side(side_o)
  );

  assign m_tdata = {1'd0, heading, side_o.cal_z, side_o.cal_y, side_o.cal_x,
                    side_o.scaled_z, side_o.scaled_y, side_o.scaled_x};

  `include "magnetometer_calibrate_heading_assert.svh"

  `MCH_ASSERT_IMP(a_ready, clk, rst, m_tvalid && !m_tready, !s_tready)
  `MCH_ASSERT_IMP(a_range, clk, rst, m_tvalid, m_tdata[110:99] < FullCircle)
  `MCH_ASSERT_NEXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule
